FILE: hdl/hvn_pkg.sv
package hvn_pkg;

  localparam int NUM_STAGES = 8;
  localparam int CORNER_W   = 24;
  localparam int WEIGHT_W   = 16;

  localparam logic [31:0] PRIME_X   = 32'd374761393;
  localparam logic [31:0] PRIME_Y   = 32'd668265263;
  localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;

  localparam logic [16:0] ONE_16    = 17'h10000;
  localparam logic [17:0] SMOOTH_K  = 18'd196608;

  typedef logic [CORNER_W-1:0] corner_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef struct packed {
    corner_t a;
    corner_t b;
    corner_t c;
    corner_t d;
  } corners_t;

endpackage

FILE: hdl/hvn_corner.sv
module hvn_corner import hvn_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  stage_en_t          stage_en,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic        [31:0] seed,
  output corners_t           corners
);

  logic [31:0] ix_r, ix1_r, iy_r, iy1_r;
  logic [31:0] ix_nxt, iy_nxt;
  logic [31:0] px0_r, px1_r, py0_r, py1_r;
  logic [31:0] m1_r [4];
  logic [31:0] m2_r [4];
  logic [31:0] h_w  [4];
  logic [31:0] hs_w [4];
  logic [31:0] g_w  [4];
  logic [31:0] f_w  [4];

  assign ix_nxt = 32'(coord_x >>> FRAC_BITS);
  assign iy_nxt = 32'(coord_y >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      ix_r  <= ix_nxt;
      ix1_r <= ix_nxt + 32'd1;
      iy_r  <= iy_nxt;
      iy1_r <= iy_nxt + 32'd1;
    end
    if (stage_en[1]) begin
      px0_r <= ix_r * PRIME_X;
      px1_r <= ix1_r * PRIME_X;
      py0_r <= iy_r * PRIME_Y;
      py1_r <= iy1_r * PRIME_Y;
    end
  end

  always_comb begin
    h_w[0] = px0_r ^ py0_r ^ seed;
    h_w[1] = px1_r ^ py0_r ^ seed;
    h_w[2] = px0_r ^ py1_r ^ seed;
    h_w[3] = px1_r ^ py1_r ^ seed;
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign hs_w[k] = h_w[k] ^ (h_w[k] >> 16);
    assign g_w[k]  = m1_r[k] ^ (m1_r[k] >> 15);
    assign f_w[k]  = m2_r[k] ^ (m2_r[k] >> 16);

    always_ff @(posedge clk) begin
      if (stage_en[2]) begin
        m1_r[k] <= hs_w[k] * MIX_MUL_A;
      end
      if (stage_en[3]) begin
        m2_r[k] <= g_w[k] * MIX_MUL_B;
      end
    end
  end

  assign corners.a = f_w[0][CORNER_W-1:0];
  assign corners.b = f_w[1][CORNER_W-1:0];
  assign corners.c = f_w[2][CORNER_W-1:0];
  assign corners.d = f_w[3][CORNER_W-1:0];

endmodule

FILE: hdl/hvn_weight.sv
module hvn_weight import hvn_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  stage_en_t   stage_en,
  input  logic [31:0] coord,
  output weight_t     weight
);

  weight_t     t_nxt;
  weight_t     t0_r, t1_r;
  logic [31:0] tt_r;
  logic [17:0] k_w;
  logic [49:0] ss_r;
  weight_t     w_r;

  if (FRAC_BITS >= WEIGHT_W) begin : g_trunc
    assign t_nxt = coord[FRAC_BITS-1 -: WEIGHT_W];
  end else begin : g_widen
    assign t_nxt = {coord[FRAC_BITS-1:0], {(WEIGHT_W-FRAC_BITS){1'b0}}};
  end

  assign k_w = SMOOTH_K - {1'b0, t1_r, 1'b0};

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      t0_r <= t_nxt;
    end
    if (stage_en[1]) begin
      tt_r <= {16'b0, t0_r} * {16'b0, t0_r};
      t1_r <= t0_r;
    end
    if (stage_en[2]) begin
      ss_r <= {18'b0, tt_r} * {32'b0, k_w};
    end
    if (stage_en[3]) begin
      w_r <= ss_r[47:32];
    end
  end

  assign weight = w_r;

endmodule

FILE: hdl/hvn_blend.sv
module hvn_blend import hvn_pkg::*; (
  input  logic      clk,
  input  stage_en_t stage_en,
  input  corners_t  corners,
  input  weight_t   weight_u,
  input  weight_t   weight_v,
  output corner_t   noise
);

  logic [16:0] u_inv_w, v_inv_w;
  logic [40:0] pa_r, pb_r, pc_r, pd_r;
  weight_t     v4_r, v5_r;
  corner_t     row0_r, row1_r;
  logic [41:0] sum0_w, sum1_w, sum2_w;
  logic [40:0] q0_r, q1_r;
  corner_t     noise_r;
  logic [16:0] u_w, v_w;

  assign u_w     = {1'b0, weight_u};
  assign v_w     = {1'b0, v5_r};
  assign u_inv_w = ONE_16 - u_w;
  assign v_inv_w = ONE_16 - v_w;

  assign sum0_w = {1'b0, pa_r} + {1'b0, pb_r};
  assign sum1_w = {1'b0, pc_r} + {1'b0, pd_r};
  assign sum2_w = {1'b0, q0_r} + {1'b0, q1_r};

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      pa_r <= {17'b0, corners.a} * {24'b0, u_inv_w};
      pb_r <= {17'b0, corners.b} * {24'b0, u_w};
      pc_r <= {17'b0, corners.c} * {24'b0, u_inv_w};
      pd_r <= {17'b0, corners.d} * {24'b0, u_w};
      v4_r <= weight_v;
    end
    if (stage_en[5]) begin
      row0_r <= sum0_w[39:16];
      row1_r <= sum1_w[39:16];
      v5_r   <= v4_r;
    end
    if (stage_en[6]) begin
      q0_r <= {17'b0, row0_r} * {24'b0, v_inv_w};
      q1_r <= {17'b0, row1_r} * {24'b0, v_w};
    end
    if (stage_en[7]) begin
      noise_r <= sum2_w[39:16];
    end
  end

  assign noise = noise_r;

endmodule

FILE: hdl/hashed_value_noise_2d.sv
// hashed_value_noise_2d: 2D value noise with smoothstep blending.
// Input channel (in_valid/in_ready): one point per transfer, in_coord_x and
// in_coord_y in signed fixed point with FRAC_BITS fraction bits.
// Output channel (out_valid/out_ready): one out_noise_value per point,
// unsigned 24 bits where 16777215 stands for 1.0, in input order.
// Config: cfg_wr_en with cfg_wr_data loads the hash seed at the clock edge;
// write it only while no point is in flight.
// Pipeline: a point passes through the eight register stages (cell floor,
// corner multiplies, two mixer multiplies, two blend multiplies and their
// sums) before out_valid rises; the result transfers once out_ready is high.
// Throughput: one point per cycle while out_ready is high.
// Reset (rst_n low, synchronous): all stage valid bits clear and the seed
// returns to 0.
// Stall: when out_ready is low, stages fill their empty slots and then
// hold; in_ready drops only once every stage holds a point.
module hashed_value_noise_2d import hvn_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [23:0] out_noise_value,
  input  logic               cfg_wr_en,
  input  logic        [31:0] cfg_wr_data
);

  logic [31:0] seed_r;
  stage_en_t   vld_r;
  stage_en_t   stage_en;
  stage_en_t   vld_in;
  corners_t    corners;
  weight_t     weight_u, weight_v;
  corner_t     noise;

  always_comb begin
    stage_en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  assign vld_in = {vld_r[NUM_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      seed_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  hvn_corner #(.FRAC_BITS(FRAC_BITS)) u_corner (
    .clk      (clk),
    .stage_en (stage_en),
    .coord_x  (in_coord_x),
    .coord_y  (in_coord_y),
    .seed     (seed_r),
    .corners  (corners)
  );

  hvn_weight #(.FRAC_BITS(FRAC_BITS)) u_weight_x (
    .clk      (clk),
    .stage_en (stage_en),
    .coord    (in_coord_x),
    .weight   (weight_u)
  );

  hvn_weight #(.FRAC_BITS(FRAC_BITS)) u_weight_y (
    .clk      (clk),
    .stage_en (stage_en),
    .coord    (in_coord_y),
    .weight   (weight_v)
  );

  hvn_blend u_blend (
    .clk      (clk),
    .stage_en (stage_en),
    .corners  (corners),
    .weight_u (weight_u),
    .weight_v (weight_v),
    .noise    (noise)
  );

  assign in_ready        = stage_en[0];
  assign out_valid       = vld_r[NUM_STAGES-1];
  assign out_noise_value = noise;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && $countones(vld_r) == NUM_STAGES))
    else $error("input stalled while the pipeline has a free slot");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !vld_r[NUM_STAGES-2]) |=> !out_valid)
    else $error("result presented twice");

  a_enter_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted point lost at first stage");
`endif

endmodule

FILE: dv/tb_top.sv
module tb_top;
  import hvn_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam logic [31:0] FRAC_MASK = (32'd1 << FRAC_BITS) - 32'd1;
  localparam int PHASE_ITEMS = 400;
  localparam int HOLD_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_DIR = 16;
  localparam int EXP_DEPTH = 64;
  localparam logic [31:0] SEED_ALL_ONES = 32'hffffffff;
  localparam logic [31:0] SEED_ZERO = 32'h00000000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        typed;
    corner_t     noise;
  } point_row_t;

  // typed rows assume the seed as it comes out of reset
  localparam point_row_t DIR_ROWS [NUM_DIR] = '{
    '{32'h00000000, 32'h00000000, 1'b1, 24'd0},
    '{32'h00010000, 32'h00000000, 1'b0, 24'd0},
    '{32'h7fffffff, 32'h7fffffff, 1'b0, 24'd0},
    '{32'h80000000, 32'h80000000, 1'b0, 24'd0},
    '{32'h80000000, 32'h7fffffff, 1'b0, 24'd0},
    '{32'hffffffff, 32'hffffffff, 1'b0, 24'd0},
    '{32'hffff0000, 32'h00000000, 1'b0, 24'd0},
    '{32'h00000000, 32'hffff8000, 1'b0, 24'd0},
    '{32'h00008000, 32'h00008000, 1'b0, 24'd0},
    '{32'h0000ffff, 32'h00000001, 1'b0, 24'd0},
    '{32'h00000001, 32'h0000ffff, 1'b0, 24'd0},
    '{32'h7fff0000, 32'h80000000, 1'b0, 24'd0},
    '{32'h12345678, 32'hedcba987, 1'b0, 24'd0},
    '{32'hfffe0001, 32'h0001fffe, 1'b0, 24'd0},
    '{32'hfffffff0, 32'h7fffffff, 1'b0, 24'd0},
    '{32'h55555555, 32'haaaaaaaa, 1'b0, 24'd0}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_coord_x;
  logic signed [31:0] in_coord_y;
  logic               out_valid;
  logic               out_ready;
  logic        [23:0] out_noise_value;
  logic               cfg_wr_en;
  logic        [31:0] cfg_wr_data;

  logic [31:0] seed_shadow;
  corner_t     exp_mem [EXP_DEPTH];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_reqs = 0;
  int unsigned holds_done = 0;

  hashed_value_noise_2d #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_noise_value (out_noise_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  function automatic logic [31:0] mix_word(logic [31:0] v);
    logic [31:0] m;
    m = v ^ (v >> 16);
    m = m * MIX_MUL_A;
    m = m ^ (m >> 15);
    m = m * MIX_MUL_B;
    m = m ^ (m >> 16);
    return m;
  endfunction

  function automatic corner_t hash_corner(logic [31:0] cx, logic [31:0] cy, logic [31:0] seed);
    logic [31:0] w;
    logic [31:0] h;
    w = (cx * PRIME_X) ^ (cy * PRIME_Y) ^ seed;
    h = mix_word(w);
    return h[23:0];
  endfunction

  function automatic logic [63:0] smooth_weight(logic [31:0] c);
    logic [63:0] f;
    logic [63:0] t;
    f = 64'(c & FRAC_MASK);
    if (FRAC_BITS >= 16) begin
      t = f >> (FRAC_BITS - 16);
    end else begin
      t = f << (16 - FRAC_BITS);
    end
    return (t * t * (64'd196608 - 64'd2 * t)) >> 32;
  endfunction

  function automatic logic [63:0] lerp_16(logic [63:0] lo, logic [63:0] hi, logic [63:0] w);
    return (lo * (64'd65536 - w) + hi * w) >> 16;
  endfunction

  function automatic corner_t predict_noise(logic [31:0] x, logic [31:0] y, logic [31:0] seed);
    logic [31:0] ix;
    logic [31:0] iy;
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] row0;
    logic [63:0] row1;
    logic [63:0] mixed;
    ix = 32'($signed(x) >>> FRAC_BITS);
    iy = 32'($signed(y) >>> FRAC_BITS);
    u = smooth_weight(x);
    v = smooth_weight(y);
    row0 = lerp_16(64'(hash_corner(ix, iy, seed)), 64'(hash_corner(ix + 32'd1, iy, seed)), u);
    row1 = lerp_16(64'(hash_corner(ix, iy + 32'd1, seed)),
                   64'(hash_corner(ix + 32'd1, iy + 32'd1, seed)), u);
    mixed = lerp_16(row0, row1, v);
    return mixed[23:0];
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    logic [15:0] frac;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: frac = r[15:0];
      1: frac = 16'h0000;
      2: frac = 16'hffff;
      default: frac = 16'h8000;
    endcase
    case ($urandom_range(0, 3))
      0: return r;
      1: return {16'(32'($urandom_range(0, 15)) - 32'd8), frac};
      2: return {r[31:16], frac};
      default: return {16'hffff, r[15:0]};
    endcase
  endfunction

  task automatic drive_point(logic [31:0] x, logic [31:0] y, logic typed, corner_t noise);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_coord_x = x;
    in_coord_y = y;
    do @(posedge clk); while (!in_ready);
    exp_mem[exp_wr % EXP_DEPTH] = typed ? noise : predict_noise(x, y, seed_shadow);
    exp_wr++;
  endtask

  task automatic write_seed(logic [31:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    seed_shadow = value;
  endtask

  task automatic run_random(int unsigned n, bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 2) hold_reqs++;
      drive_point(rand_coord(), rand_coord(), 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("** hashed_value_noise_2d: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_reqs) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      out_ready = ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_wr == exp_rd) begin
        $error("out_noise_value: expected none, actual %0d", out_noise_value);
        fail_count++;
      end else begin
        if (out_noise_value !== exp_mem[exp_rd % EXP_DEPTH]) begin
          $error("out_noise_value: expected %0d, actual %0d", exp_mem[exp_rd % EXP_DEPTH],
                 out_noise_value);
          fail_count++;
        end
        exp_rd++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    seed_shadow = SEED_ZERO;
    src_idle_pct = 16;
    sink_idle_pct = 76;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      drive_point(DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].typed, DIR_ROWS[i].noise);
    end

    write_seed(SEED_ALL_ONES);
    run_random(PHASE_ITEMS, 1'b0);

    src_idle_pct = 76;
    sink_idle_pct = 16;
    write_seed($urandom);
    run_random(PHASE_ITEMS, 1'b0);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_seed(SEED_ZERO);
    run_random(PHASE_ITEMS, 1'b1);

    @(negedge clk);
    in_valid = 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (2 * NUM_STAGES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** hashed_value_noise_2d: PASSED **");
    end else begin
      $display("** hashed_value_noise_2d: FAILED **");
    end
    $finish;
  end

endmodule
